FILE: rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg: shared types and constants of the blink and PERCLOS tracker.
// Widths, depths and limits used by the core and its divider.
// ----------------------------------------------------------------------------
package bpt_pkg;

    localparam int WindowDepth = 1024;
    localparam int StampDepth  = 1024;
    localparam int WinIdxW     = $clog2(WindowDepth);
    localparam int StampIdxW   = $clog2(StampDepth);
    localparam int WinCntW     = WinIdxW + 1;
    localparam int StampCntW   = StampIdxW + 1;

    localparam int DivW = 64;

    localparam logic [7:0]  RunMin       = 8'd2;
    localparam logic [7:0]  RunMax       = 8'd25;
    localparam logic [47:0] MinuteUs     = 48'd60000000;
    localparam logic [47:0] DefFrameUs   = 48'd7680;
    localparam logic [31:0] MeanResetUs  = 32'd150000;
    localparam logic [47:0] Max48        = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] Max32        = 32'hFFFF_FFFF;
    localparam logic [63:0] FrameNum     = 64'd256000000;
    localparam logic [63:0] RateScale    = 64'd6000000000;

    localparam logic [0:0] RegThreshold = 1'b0;
    localparam logic [0:0] RegWindow    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAME_DIV,
        ST_FRAME_WAIT,
        ST_FLAG_DROP,
        ST_FLAG_RD,
        ST_UPDATE,
        ST_MEAN_WAIT,
        ST_STAMP_RD,
        ST_STAMP_CHK,
        ST_FRAC_WAIT,
        ST_RATE_MUL,
        ST_RATE_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic            start;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
    } div_req_t;

endpackage

FILE: rtl/core/blink_perclos_tracker_core.sv
// ----------------------------------------------------------------------------
// blink_perclos_tracker_core: per-frame eye closure and blink statistics.
// Averages two eye aspect ratios, tracks PERCLOS and blink rate and duration.
// ----------------------------------------------------------------------------
// Usage: one s_ beat carries one video frame's left and right eye aspect
// ratios and frame rate; exactly one m_ beat comes back per frame with the
// echoed ratios, their mean, the closed flag, PERCLOS, blink total, blink
// rate and mean blink duration. Configuration is written through cfg_we,
// cfg_addr and cfg_data while the core is idle; the core does not enforce
// this, so the user must keep to it.
// The path from the input beat to m_tvalid is shortest at the default
// frame rate with no blink stamps held, and longest when frame time, mean
// duration, PERCLOS and rate are all divided; each evicted timestamp adds
// to it. All divisions run through one shared serial divider, and the
// time-stamp eviction walks the stamp memory one entry at a time.
// The core takes one frame at a time: s_tready is high only when idle, so a
// new frame can start in the cycle after the previous result beat is taken.
// The result sits in an output register; while the receiver stalls it
// holds and no new frame is taken.
// Reset (aresetn low, synchronous) clears counters and pointers, restores
// the default registers and the mean duration of 150000 us. The flag and
// stamp memories are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module blink_perclos_tracker_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ear_left[15:0], ear_right[31:16], frame_rate[47:32]
    input  logic [47:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_echo[15:0], right_echo[31:16], ear_mean[47:32], eye_closed[48],
    // closed_fraction[64:49], blink_total[96:65], blinks_per_minute[112:97],
    // mean_blink_us[144:113], zero fill [151:145]
    output logic [151:0] m_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [15:0]  cfg_data
);

    localparam int WIW = bpt_pkg::WinIdxW;
    localparam int WCW = bpt_pkg::WinCntW;
    localparam int SIW = bpt_pkg::StampIdxW;
    localparam int SCW = bpt_pkg::StampCntW;

    bpt_pkg::state_t state_reg, state_next;

    logic [15:0]  thr_reg;
    logic [10:0]  win_reg;

    logic [15:0]  left_reg, left_next, right_reg, right_next, fps_reg, fps_next;
    logic [15:0]  mean_reg, mean_next;
    logic         closed_reg, closed_next;
    logic [47:0]  frame_us_reg, frame_us_next;

    logic         flag_mem [bpt_pkg::WindowDepth];
    logic [47:0]  stamp_mem [bpt_pkg::StampDepth];
    logic         flag_rd_reg;
    logic [47:0]  stamp_rd_reg;
    logic         flag_we, stamp_we;
    logic [WIW-1:0] flag_waddr, flag_raddr;
    logic [SIW-1:0] stamp_waddr;

    logic [WIW-1:0] fhead_reg, fhead_next;
    logic [WCW-1:0] ffill_reg, ffill_next, cwin_reg, cwin_next;
    logic         prev_reg, prev_next;
    logic [7:0]   run_reg, run_next;
    logic [31:0]  blinks_reg, blinks_next;
    logic [47:0]  tsum_reg, tsum_next;
    logic [31:0]  meandur_reg, meandur_next;
    logic [47:0]  elapsed_reg, elapsed_next;
    logic [SIW-1:0] shead_reg, shead_next;
    logic [SCW-1:0] scount_reg, scount_next;
    logic [15:0]  frac_reg, frac_next, rate_reg, rate_next;
    logic         mvalid_reg, mvalid_next;

    bpt_pkg::div_req_t div_req;
    logic         div_done;
    logic [63:0]  div_quot;

    logic [WCW-1:0] win_eff;
    logic [48:0]  esum;
    logic [55:0]  dur;
    logic [48:0]  tsum_add;
    logic [47:0]  rwin;

    bpt_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 16'd3277;
            win_reg <= 11'd900;
        end else if (cfg_we) begin
            case (cfg_addr)
                bpt_pkg::RegThreshold: thr_reg <= cfg_data;
                bpt_pkg::RegWindow:    win_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Window length clamped to 1..WindowDepth.
    always_comb begin
        if (win_reg == 11'd0) win_eff = WCW'(1);
        else if (32'(win_reg) > bpt_pkg::WindowDepth) win_eff = WCW'(bpt_pkg::WindowDepth);
        else win_eff = WCW'(win_reg);
    end

    always_ff @(posedge aclk) begin
        if (flag_we) flag_mem[flag_waddr] <= closed_reg;
        flag_rd_reg <= flag_mem[flag_raddr];
        if (stamp_we) stamp_mem[stamp_waddr] <= elapsed_reg;
        stamp_rd_reg <= stamp_mem[shead_reg];
    end

    assign esum     = {1'b0, elapsed_reg} + {1'b0, frame_us_reg};
    assign dur      = 56'(run_reg) * 56'(frame_us_reg);
    assign tsum_add = {1'b0, tsum_reg} + ((dur > 56'(bpt_pkg::Max48)) ?
                      {1'b0, bpt_pkg::Max48} : dur[48:0]);
    assign rwin     = (elapsed_reg < bpt_pkg::MinuteUs) ? elapsed_reg : bpt_pkg::MinuteUs;

    always_comb begin
        state_next   = state_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        fps_next     = fps_reg;
        mean_next    = mean_reg;
        closed_next  = closed_reg;
        frame_us_next = frame_us_reg;
        fhead_next   = fhead_reg;
        ffill_next   = ffill_reg;
        cwin_next    = cwin_reg;
        prev_next    = prev_reg;
        run_next     = run_reg;
        blinks_next  = blinks_reg;
        tsum_next    = tsum_reg;
        meandur_next = meandur_reg;
        elapsed_next = elapsed_reg;
        shead_next   = shead_reg;
        scount_next  = scount_reg;
        frac_next    = frac_reg;
        rate_next    = rate_reg;
        mvalid_next  = mvalid_reg;
        div_req      = '0;
        flag_we      = 1'b0;
        flag_waddr   = fhead_reg + WIW'(ffill_reg);
        flag_raddr   = fhead_reg;
        stamp_we     = 1'b0;
        stamp_waddr  = shead_reg + SIW'(scount_reg);
        s_tready     = 1'b0;

        case (state_reg)
            bpt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    left_next  = s_tdata[15:0];
                    right_next = s_tdata[31:16];
                    fps_next   = s_tdata[47:32];
                    mean_next  = 16'((17'(s_tdata[15:0]) + 17'(s_tdata[31:16])) >> 1);
                    state_next = bpt_pkg::ST_FRAME_DIV;
                end
            end
            bpt_pkg::ST_FRAME_DIV: begin
                closed_next = (mean_reg < thr_reg);
                if (fps_reg == 16'd0) begin
                    frame_us_next = bpt_pkg::DefFrameUs;
                    state_next    = bpt_pkg::ST_FLAG_DROP;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = bpt_pkg::FrameNum;
                    div_req.den   = 64'(fps_reg);
                    state_next    = bpt_pkg::ST_FRAME_WAIT;
                end
            end
            bpt_pkg::ST_FRAME_WAIT: begin
                if (div_done) begin
                    frame_us_next = div_quot[47:0];
                    state_next    = bpt_pkg::ST_FLAG_DROP;
                end
            end
            bpt_pkg::ST_FLAG_DROP: begin
                // Push the flag; the head entry read lands next cycle. On a
                // full ring the write lands on the head, and the count runs
                // one past the depth until the old head flag is dropped.
                flag_we    = 1'b1;
                ffill_next = ffill_reg + WCW'(1);
                cwin_next  = cwin_reg + WCW'(closed_reg);
                state_next = (ffill_reg + WCW'(1) > win_eff) ?
                             bpt_pkg::ST_FLAG_RD : bpt_pkg::ST_UPDATE;
            end
            bpt_pkg::ST_FLAG_RD: begin
                // The read taken at the write edge holds the old head flag.
                cwin_next  = cwin_reg - WCW'(flag_rd_reg);
                ffill_next = ffill_reg - WCW'(1);
                fhead_next = fhead_reg + WIW'(1);
                state_next = bpt_pkg::ST_UPDATE;
            end
            bpt_pkg::ST_UPDATE: begin
                elapsed_next = esum[48] ? bpt_pkg::Max48 : esum[47:0];
                prev_next    = closed_reg;
                state_next   = bpt_pkg::ST_FRAC_WAIT;
                div_req.start = (ffill_reg != '0);
                div_req.num  = 64'(cwin_reg) << 16;
                div_req.den  = 64'(ffill_reg);
                if (closed_reg) begin
                    if (run_reg != 8'd255) run_next = run_reg + 8'd1;
                end else if (prev_reg) begin
                    run_next = 8'd0;
                    if (run_reg >= bpt_pkg::RunMin && run_reg <= bpt_pkg::RunMax) begin
                        if (blinks_reg != bpt_pkg::Max32) blinks_next = blinks_reg + 32'd1;
                        tsum_next = tsum_add[48] ? bpt_pkg::Max48 : tsum_add[47:0];
                        div_req.start = 1'b1;
                        div_req.num   = 64'(tsum_add[48] ? bpt_pkg::Max48 : tsum_add[47:0]);
                        div_req.den   = 64'(blinks_reg != bpt_pkg::Max32 ?
                                            blinks_reg + 32'd1 : blinks_reg);
                        state_next    = bpt_pkg::ST_MEAN_WAIT;
                    end
                end
                if (state_next == bpt_pkg::ST_FRAC_WAIT && ffill_reg == '0) begin
                    frac_next  = 16'd0;
                    state_next = bpt_pkg::ST_RATE_MUL;
                end
            end
            bpt_pkg::ST_MEAN_WAIT: begin
                if (div_done) begin
                    meandur_next = (div_quot > 64'(bpt_pkg::Max32)) ? bpt_pkg::Max32
                                                                    : div_quot[31:0];
                    // Push the stamp at the new elapsed time.
                    stamp_we = 1'b1;
                    if (32'(scount_reg) >= bpt_pkg::StampDepth) begin
                        shead_next  = shead_reg + SIW'(1);
                        stamp_waddr = shead_reg;
                    end else begin
                        scount_next = scount_reg + SCW'(1);
                    end
                    state_next = bpt_pkg::ST_STAMP_RD;
                end
            end
            bpt_pkg::ST_STAMP_RD: begin
                state_next = bpt_pkg::ST_STAMP_CHK;
            end
            bpt_pkg::ST_STAMP_CHK: begin
                if (scount_reg != '0 && elapsed_reg - stamp_rd_reg > bpt_pkg::MinuteUs) begin
                    shead_next  = shead_reg + SIW'(1);
                    scount_next = scount_reg - SCW'(1);
                    state_next  = bpt_pkg::ST_STAMP_RD;
                end else begin
                    div_req.start = (ffill_reg != '0);
                    div_req.num   = 64'(cwin_reg) << 16;
                    div_req.den   = 64'(ffill_reg);
                    if (ffill_reg == '0) begin
                        frac_next  = 16'd0;
                        state_next = bpt_pkg::ST_RATE_MUL;
                    end else begin
                        state_next = bpt_pkg::ST_FRAC_WAIT;
                    end
                end
            end
            bpt_pkg::ST_FRAC_WAIT: begin
                if (div_done) begin
                    frac_next  = (div_quot > 64'hFFFF) ? 16'hFFFF : div_quot[15:0];
                    state_next = bpt_pkg::ST_RATE_MUL;
                end
            end
            bpt_pkg::ST_RATE_MUL: begin
                state_next = bpt_pkg::ST_RATE_WAIT;
                if (scount_reg == '0 || rwin == 48'd0) begin
                    rate_next  = 16'd0;
                    state_next = bpt_pkg::ST_OUT;
                    mvalid_next = 1'b1;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = 64'(scount_reg) * bpt_pkg::RateScale;
                    div_req.den   = 64'(rwin);
                end
            end
            bpt_pkg::ST_RATE_WAIT: begin
                if (div_done) begin
                    rate_next   = (div_quot > 64'hFFFF) ? 16'hFFFF : div_quot[15:0];
                    mvalid_next = 1'b1;
                    state_next  = bpt_pkg::ST_OUT;
                end
            end
            bpt_pkg::ST_OUT: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    state_next  = bpt_pkg::ST_IDLE;
                end
            end
            default: state_next = bpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        left_reg     <= left_next;
        right_reg    <= right_next;
        fps_reg      <= fps_next;
        mean_reg     <= mean_next;
        closed_reg   <= closed_next;
        frame_us_reg <= frame_us_next;
        frac_reg     <= frac_next;
        rate_reg     <= rate_next;
        if (!aresetn) begin
            state_reg   <= bpt_pkg::ST_IDLE;
            fhead_reg   <= '0;
            ffill_reg   <= '0;
            cwin_reg    <= '0;
            prev_reg    <= 1'b0;
            run_reg     <= 8'd0;
            blinks_reg  <= 32'd0;
            tsum_reg    <= 48'd0;
            meandur_reg <= bpt_pkg::MeanResetUs;
            elapsed_reg <= 48'd0;
            shead_reg   <= '0;
            scount_reg  <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fhead_reg   <= fhead_next;
            ffill_reg   <= ffill_next;
            cwin_reg    <= cwin_next;
            prev_reg    <= prev_next;
            run_reg     <= run_next;
            blinks_reg  <= blinks_next;
            tsum_reg    <= tsum_next;
            meandur_reg <= meandur_next;
            elapsed_reg <= elapsed_next;
            shead_reg   <= shead_next;
            scount_reg  <= scount_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, meandur_reg, rate_reg, blinks_reg, frac_reg, closed_reg,
                       mean_reg, right_reg, left_reg};

endmodule

FILE: rtl/core/bpt_divider.sv
// ----------------------------------------------------------------------------
// bpt_divider: shared restoring divider.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpt_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bpt_pkg::div_req_t           req,
    output logic                        done,
    output logic [bpt_pkg::DivW-1:0]    quot
);

    logic [bpt_pkg::DivW-1:0] quot_reg, quot_next;
    logic [bpt_pkg::DivW:0]   rem_reg, rem_next;
    logic [bpt_pkg::DivW-1:0] den_reg, den_next;
    logic [6:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [bpt_pkg::DivW:0]   trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[bpt_pkg::DivW-1:0], quot_reg[bpt_pkg::DivW-1]};
        if (req.start) begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[bpt_pkg::DivW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next     = trial - {1'b0, den_reg};
                quot_next[0] = 1'b1;
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(bpt_pkg::DivW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: rtl/core/bpt_checker.sv
// ----------------------------------------------------------------------------
// bpt_checker: port-level checks of the blink and PERCLOS tracker.
// Attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module bpt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("core not busy after taking a frame");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[151:145] == 7'd0)
        else $error("fill bits not zero");

endmodule

bind blink_perclos_tracker_core bpt_checker u_bpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb_blink_perclos_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_blink_perclos_tracker_core: self-checking bench for the blink tracker.
// Drives frames with random idling, predicts every result beat with its own
// model of the PERCLOS window and blink statistics, and compares fields.
// ----------------------------------------------------------------------------
module tb_blink_perclos_tracker_core;

    // Expected output of one frame.
    typedef struct {
        logic [15:0] left_echo;
        logic [15:0] right_echo;
        logic [15:0] ear_mean;
        logic        eye_closed;
        logic [15:0] closed_fraction;
        logic [31:0] blink_total;
        logic [15:0] blinks_per_minute;
        logic [31:0] mean_blink_us;
    } frame_stats_t;

    // Tracker predictor and result store in one small scoreboard.
    class blink_scoreboard;
        logic [15:0] thresh;
        logic [10:0] win_len;
        bit          flags[bpt_pkg::WindowDepth];
        int unsigned fhead, ffill, fclosed;
        bit          prev_closed;
        int unsigned run_len;
        longint unsigned blinks, dur_sum, mean_us, elapsed;
        longint unsigned stamps[bpt_pkg::StampDepth];
        int unsigned shead, scount;
        frame_stats_t pending[$];
        int errors;

        function void reset_state();
            thresh = 16'd3277; win_len = 11'd900;
            fhead = 0; ffill = 0; fclosed = 0; prev_closed = 0; run_len = 0;
            blinks = 0; dur_sum = 0; mean_us = 150000; elapsed = 0;
            shead = 0; scount = 0; errors = 0;
            pending.delete();
        endfunction

        function void write_reg(logic [0:0] idx, logic [15:0] val);
            if (idx == bpt_pkg::RegThreshold) thresh = val;
            else win_len = val[10:0];
        endfunction

        function longint unsigned sat48(longint unsigned v);
            return (v > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : v;
        endfunction

        // Note one accepted frame and compute its expected result.
        function void note_frame(logic [15:0] l, logic [15:0] r, logic [15:0] fps);
            frame_stats_t e;
            int unsigned w;
            bit c;
            longint unsigned fus, m, span, rate, frac;
            e.left_echo = l; e.right_echo = r;
            e.ear_mean = 16'((17'(l) + 17'(r)) >> 1);
            c = e.ear_mean < thresh;
            fus = (fps == 0) ? 7680 : 256000000 / fps;
            w = (win_len == 0) ? 1 : (win_len > bpt_pkg::WindowDepth ?
                                      bpt_pkg::WindowDepth : win_len);
            if (ffill >= bpt_pkg::WindowDepth) begin
                fclosed = fclosed - flags[fhead] + c;
                flags[fhead] = c;
                fhead = (fhead + 1) % bpt_pkg::WindowDepth;
            end else begin
                flags[(fhead + ffill) % bpt_pkg::WindowDepth] = c;
                ffill++; fclosed += c;
                if (ffill > w) begin
                    fclosed -= flags[fhead];
                    fhead = (fhead + 1) % bpt_pkg::WindowDepth;
                    ffill--;
                end
            end
            elapsed = sat48(elapsed + fus);
            if (c) begin
                if (run_len < 255) run_len++;
            end else if (prev_closed) begin
                if (run_len >= 2 && run_len <= 25) begin
                    if (blinks < 64'hFFFF_FFFF) blinks++;
                    dur_sum = sat48(dur_sum + run_len * fus);
                    m = dur_sum / blinks;
                    mean_us = (m > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : m;
                    if (scount >= bpt_pkg::StampDepth) begin
                        shead = (shead + 1) % bpt_pkg::StampDepth;
                        scount--;
                    end
                    stamps[(shead + scount) % bpt_pkg::StampDepth] = elapsed;
                    scount++;
                    while (scount > 0 && elapsed - stamps[shead] > 60000000) begin
                        shead = (shead + 1) % bpt_pkg::StampDepth;
                        scount--;
                    end
                end
                run_len = 0;
            end
            prev_closed = c;
            frac = 0;
            if (ffill > 0) begin
                frac = (longint'(fclosed) << 16) / ffill;
                if (frac > 16'hFFFF) frac = 16'hFFFF;
            end
            rate = 0;
            if (scount > 0) begin
                span = (elapsed < 60000000) ? elapsed : 60000000;
                if (span > 0) begin
                    rate = (longint'(scount) * 64'd6000000000) / span;
                    if (rate > 16'hFFFF) rate = 16'hFFFF;
                end
            end
            e.eye_closed = c;
            e.closed_fraction = frac[15:0];
            e.blink_total = blinks[31:0];
            e.blinks_per_minute = rate[15:0];
            e.mean_blink_us = mean_us[31:0];
            pending = {pending, e};
        endfunction

        function void report(string f, longint unsigned exp_v, longint unsigned act_v);
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, f, exp_v, act_v);
            errors++;
        endfunction

        // Compare one result beat with the oldest expected frame.
        function void check_result(logic [151:0] d);
            frame_stats_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, d);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (d[15:0] !== e.left_echo) report("left_echo", e.left_echo, d[15:0]);
            if (d[31:16] !== e.right_echo) report("right_echo", e.right_echo, d[31:16]);
            if (d[47:32] !== e.ear_mean) report("ear_mean", e.ear_mean, d[47:32]);
            if (d[48] !== e.eye_closed) report("eye_closed", e.eye_closed, d[48]);
            if (d[64:49] !== e.closed_fraction)
                report("closed_fraction", e.closed_fraction, d[64:49]);
            if (d[96:65] !== e.blink_total) report("blink_total", e.blink_total, d[96:65]);
            if (d[112:97] !== e.blinks_per_minute)
                report("blinks_per_minute", e.blinks_per_minute, d[112:97]);
            if (d[144:113] !== e.mean_blink_us)
                report("mean_blink_us", e.mean_blink_us, d[144:113]);
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // ear_left[15:0], ear_right[31:16], frame_rate[47:32]
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // left_echo[15:0], right_echo[31:16], ear_mean[47:32], eye_closed[48],
    // closed_fraction[64:49], blink_total[96:65], blinks_per_minute[112:97],
    // mean_blink_us[144:113]
    logic [151:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_addr = bpt_pkg::RegThreshold;
    logic [15:0]  cfg_data = '0;

    blink_scoreboard tracker_sb = new();
    // Idling is switched off for a stretch in the middle of the run.
    bit           steady_flow = 0;
    // When set, the receiver refuses every result beat.
    bit           hold_results = 0;
    longint       cycle_count = 0;
    // Number of frames accepted so far.
    int unsigned  frames_sent = 0;

    blink_perclos_tracker_core dut (.*);

    always #5 aclk = ~aclk;

    // Cycle counter and watchdog. The limit lies far above the time the slowest
    // frame needs, eviction and receiver stalls included.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: accepts beats with random stalls; the check uses the values
    // sampled at the edge where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker_sb.check_result(m_tdata);
        m_tready <= !hold_results && (steady_flow || $urandom_range(99) >= 37);
    end

    // Write one register while the core is idle.
    task automatic write_cfg(logic [0:0] idx, logic [15:0] val);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        tracker_sb.write_reg(idx, val);
    endtask

    // Offer one frame, idling first at random, and wait for its acceptance.
    // The valid stays up after acceptance; an idle cycle or drain drops it.
    task automatic send_frame(logic [15:0] l, logic [15:0] r, logic [15:0] fps);
        while (!steady_flow && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= {fps, r, l};
        do @(posedge aclk); while (!s_tready);
        tracker_sb.note_frame(l, r, fps);
        frames_sent++;
    endtask

    // Wait for every result to be drained, plus the frame latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker_sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // Random EAR value that is either clearly open or clearly closed
    // relative to the current threshold, occasionally fully random.
    function automatic logic [15:0] pick_ear(bit want_closed);
        int unsigned t = tracker_sb.thresh;
        if ($urandom_range(9) == 0) return 16'($urandom_range(16'hFFFF));
        if (want_closed) return (t == 0) ? 16'd0 : 16'($urandom_range(t - 1));
        return 16'($urandom_range(16'hFFFF, (t > 16'hFFFF) ? 16'hFFFF : t));
    endfunction

    // A well-formed stretch of open frames followed by a closed run.
    task automatic send_blink_seq(int unsigned runlen, logic [15:0] fps);
        logic [15:0] e;
        repeat ($urandom_range(4, 1)) begin
            e = pick_ear(0);
            send_frame(e, e, fps);
        end
        repeat (runlen) begin
            e = pick_ear(1);
            send_frame(e, e, fps);
        end
    endtask

    function automatic logic [15:0] pick_fps();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'($urandom_range(16'hFFFF));
            2: return 16'($urandom_range(16'd255, 16'd1));
            default: return 16'($urandom_range(16'd60 << 8, 16'd15 << 8));
        endcase
    endfunction

    initial begin
        tracker_sb.reset_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames: field extremes, default frame rate, slow and fast
        // frame rates, a short blink, a too-long run and a single closed frame.
        send_frame(16'h0000, 16'h0000, 16'h0000);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(16'h0000, 16'hFFFF, 16'h0001);
        send_frame(16'h0100, 16'h0100, 16'h1E00);
        send_frame(16'h0100, 16'h0100, 16'h1E00);
        send_frame(16'h4000, 16'h4000, 16'h1E00);
        send_frame(16'h0000, 16'h0000, 16'h1E00);
        send_frame(16'h4000, 16'h4000, 16'h1E00);
        repeat (27) send_frame(16'h0010, 16'h0020, 16'h0000);
        send_frame(16'h4000, 16'hAAAA, 16'h5555);
        drain();

        // Small window and extreme thresholds.
        write_cfg(bpt_pkg::RegWindow, 16'd1);
        write_cfg(bpt_pkg::RegThreshold, 16'hFFFF);
        for (int i = 0; i < 25; i++) send_blink_seq($urandom_range(30, 1), pick_fps());
        drain();
        write_cfg(bpt_pkg::RegWindow, 16'd0);
        write_cfg(bpt_pkg::RegThreshold, 16'd0);
        for (int i = 0; i < 20; i++) send_frame(16'($urandom), 16'($urandom), pick_fps());
        drain();

        // Steady flow, largest and oversized window; receiver holds off for a
        // long stretch so the core fills up and stalls its input.
        write_cfg(bpt_pkg::RegWindow, 16'd2047);
        write_cfg(bpt_pkg::RegThreshold, 16'd3277);
        steady_flow = 1;
        fork
            begin
                hold_results = 1;
                repeat (3000) @(posedge aclk);
                hold_results = 0;
            end
            for (int i = 0; i < 20; i++) send_blink_seq($urandom_range(25, 2), 16'h1E00);
        join
        steady_flow = 0;
        drain();

        // Random part with a changing window; windows shrink while full.
        while (frames_sent < 1300) begin
            write_cfg(bpt_pkg::RegWindow,
                      $urandom_range(3) == 0 ? 16'd1024 : 16'($urandom_range(40, 1)));
            write_cfg(bpt_pkg::RegThreshold, 16'($urandom_range(16'h3000, 16'h0800)));
            repeat (10) begin
                if ($urandom_range(4) == 0) begin
                    send_frame(16'($urandom), 16'($urandom), pick_fps());
                end else begin
                    send_blink_seq($urandom_range(27, 1), pick_fps());
                end
            end
            drain();
        end

        if (tracker_sb.errors == 0 && tracker_sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (tracker_sb.pending.size() != 0)
                $display("%0t: %0d results missing, expected 0, actual %0d", $time,
                         tracker_sb.pending.size(), tracker_sb.pending.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
